// ===== design/tseq_pkg.sv =====
// Shared types, codes and the note period table of the tune sequencer.
package tseq_pkg;

   localparam int unsigned SONG_BYTES_DEF = 256;
   localparam int unsigned NOTE_COUNT     = 11;
   localparam int unsigned PERIOD_W       = 10;

   // request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_RESTART = 2'd1,
      REQ_TICK    = 2'd2
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_SONG_LENGTH   = 2'd0,
      CSR_LOOP_ENABLE   = 2'd1,
      CSR_MUSIC_ENABLE  = 2'd2,
      CSR_SUSTAIN_TICKS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic                last;
   } result_type;

   // results handed to the response queue in the same cycle
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   localparam logic [PERIOD_W-1:0] TONE_TABLE [NOTE_COUNT] = '{
      10'd0, 10'd428, 10'd403, 10'd381, 10'd359, 10'd340,
      10'd89, 10'd95, 10'd84, 10'd80, 10'd320
   };

   // note index to tone divider; unknown notes are silent
   function automatic logic [PERIOD_W-1:0] tone_of(input logic [7:0] note);
      logic [PERIOD_W-1:0] p;
      p = '0;
      if (note < 8'(NOTE_COUNT)) begin
         p = TONE_TABLE[note[3:0]];
      end
      return p;
   endfunction

endpackage

// ===== design/tseq_song_mem.sv =====
// Song store: one write port, two registered read ports.
module tseq_song_mem
   import tseq_pkg::*;
#(
   parameter int unsigned SONG_BYTES = SONG_BYTES_DEF,
   localparam int unsigned AW = $clog2(SONG_BYTES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr0,
   input  logic [AW-1:0] rd_addr1,
   output logic [7:0]    rd_data0,
   output logic [7:0]    rd_data1
);

   logic [7:0] mem [SONG_BYTES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-before-write; the top never reads an entry in the cycle it is written for use
   always_ff @(posedge clock) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule

// ===== design/tseq_rsp_queue.sv =====
// Two-entry response queue between the sequencer and the result channel.
module tseq_rsp_queue
   import tseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  push_type    push,
   output logic [1:0]  fill,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);

   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic [1:0] cnt_p;

   assign pop = (count_ff != 2'd0) && rsp_tready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_p    = count_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         cnt_p    = count_ff - 2'd1;
      end
      if (push.count != 2'd0) begin
         if (cnt_p == 2'd0) begin
            slot0_in = push.first;
         end else begin
            slot1_in = push.first;
         end
      end
      if (push.count == 2'd2) begin
         slot1_in = push.second;
      end
      count_in = cnt_p + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign fill       = count_ff;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {(16 - PERIOD_W)'(0), slot0_ff.period};
   assign rsp_tlast  = slot0_ff.last;

`ifndef SYNTHESIS
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("response queue over full");

   a_pair_empty: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> count_ff == 2'd0)
      else $error("result pair pushed into a non-empty queue");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> count_ff == $past(count_ff) - 2'd1)
      else $error("queue fill did not drop on pop");
`endif

endmodule

// ===== design/tune_sequencer_core.sv =====
// Top level of the tick-driven tune sequencer.
// Plays a song of (note index, delay) byte pairs held in an on-chip song store.
// Items on req_ are song byte writes, restarts and timer ticks; a tick may start
// the next note (tone divider out), count a delay down, or end a note with one
// silence item. Results leave on rsp_ with tlast on the final result of a tick.
// Timing: one request item per cycle sustained while no tick waits for room
// in the response queue. A request is accepted into a single work stage and
// retired once that queue has room; its results are registered there and leave
// on rsp_. The two registered read ports of the song store are addressed from
// the next play position, so the note and delay bytes are ready when a tick
// retires. A tick retires only when the two-entry response queue has room for
// all its results: with rsp_tready held high, a tick that ends a non-looping
// song gives two results and waits while a result is still queued, and the
// result tick right behind it waits too. Writes go to the store at acceptance.
// No clearing pass: song bytes must be written before they are played.
module tune_sequencer_core
   import tseq_pkg::*;
#(
   parameter int unsigned SONG_BYTES = SONG_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] song_addr, [15:8] song_byte
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] tone_period, rest zero
   output logic        rsp_tlast,   // last
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int unsigned AW = $clog2(SONG_BYTES);
   // position width: covers the play position plus one and any store address
   localparam int unsigned PW = (AW > 9) ? AW : 9;
   localparam int unsigned CW = PW + 1;
   localparam logic [CW-1:0] DEPTH = CW'(SONG_BYTES);

   // configuration
   logic [7:0] song_length_ff;
   logic       loop_enable_ff;
   logic       music_enable_ff;
   logic [3:0] sustain_ticks_ff;

   // playback state
   logic [7:0] note_pos_ff, note_pos_in, note_pos_nx;
   logic [7:0] delay_ff, delay_in, delay_nx;
   logic [3:0] sustain_ff, sustain_in, sustain_nx;
   logic       silence_ff, silence_in, silence_nx;

   // work stage
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_type_ff;
   logic       s1_go;
   logic       req_acc;

   // store access
   logic          wr_en;
   logic [PW-1:0] wr_pos;
   logic [PW-1:0] rd_pos0, rd_pos1;
   logic [7:0]    rd_data0, rd_data1;
   logic [7:0]    note_byte, delay_byte;
   logic [8:0]    pos1;
   logic [8:0]    pos_next;
   logic          song_end;
   logic [PERIOD_W-1:0] period;

   // results
   push_type   push;
   result_type res_first, res_second;
   logic [1:0] nres;
   logic [1:0] fill;
   logic       emit_quiet;

   //--------------------------------------------------------------------
   // configuration port
   //--------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         song_length_ff   <= 8'd0;
         loop_enable_ff   <= 1'b0;
         music_enable_ff  <= 1'b0;
         sustain_ticks_ff <= 4'd10;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SONG_LENGTH:   song_length_ff   <= csr_wdata;
            CSR_LOOP_ENABLE:   loop_enable_ff   <= csr_wdata[0];
            CSR_MUSIC_ENABLE:  music_enable_ff  <= csr_wdata[0];
            CSR_SUSTAIN_TICKS: sustain_ticks_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   //--------------------------------------------------------------------
   // acceptance and song store writes
   //--------------------------------------------------------------------
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_acc    = req_tvalid && req_tready;

   // writes past the store depth are dropped
   assign wr_pos = PW'(req_tdata[7:0]);
   assign wr_en  = req_acc && (req_tuser == REQ_WRITE) && (CW'(wr_pos) < DEPTH);

   assign s1_valid_in = req_acc || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_type_ff <= req_tuser;
      end
   end

   //--------------------------------------------------------------------
   // song store, read at the position the play state will hold next
   //--------------------------------------------------------------------
   assign rd_pos0 = PW'(note_pos_in);
   assign rd_pos1 = PW'(note_pos_in) + PW'(1);

   tseq_song_mem #(
      .SONG_BYTES (SONG_BYTES)
   ) u_song_mem (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_pos[AW-1:0]),
      .wr_data  (req_tdata[15:8]),
      .rd_addr0 (rd_pos0[AW-1:0]),
      .rd_addr1 (rd_pos1[AW-1:0]),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   // reads past the song or past the store give zero
   assign pos1 = {1'b0, note_pos_ff} + 9'd1;
   assign note_byte  = ((note_pos_ff < song_length_ff) &&
                        (CW'(note_pos_ff) < DEPTH)) ? rd_data0 : 8'd0;
   assign delay_byte = ((pos1 < {1'b0, song_length_ff}) &&
                        (CW'(pos1) < DEPTH)) ? rd_data1 : 8'd0;

   assign period   = tone_of(note_byte);
   assign pos_next = {1'b0, note_pos_ff} + 9'd2;
   assign song_end = (pos_next >= {1'b0, song_length_ff});

   //--------------------------------------------------------------------
   // tick / restart evaluation in the work stage
   //--------------------------------------------------------------------
   always_comb begin
      note_pos_nx = note_pos_ff;
      delay_nx    = delay_ff;
      sustain_nx  = sustain_ff;
      silence_nx  = silence_ff;
      nres        = 2'd0;
      emit_quiet  = 1'b0;
      res_first   = '{period: period, last: 1'b1};
      res_second  = '{period: '0, last: 1'b1};
      case (s1_type_ff)
         REQ_RESTART: begin
            note_pos_nx = 8'd0;
            delay_nx    = 8'd0;
            sustain_nx  = 4'd0;
            silence_nx  = 1'b1;
         end
         REQ_TICK: begin
            if (delay_ff == 8'd0) begin
               if (music_enable_ff && (note_pos_ff < song_length_ff)) begin
                  // start the next note
                  if (period != '0) begin
                     silence_nx = 1'b0;
                  end
                  sustain_nx = sustain_ticks_ff;
                  delay_nx   = delay_byte;
                  nres       = 2'd1;
                  if (!song_end) begin
                     note_pos_nx = pos_next[7:0];
                  end else if (loop_enable_ff) begin
                     note_pos_nx = 8'd0;
                  end else begin
                     // stop: note then a trailing silence
                     note_pos_nx = pos_next[8] ? 8'hFF : pos_next[7:0];
                     nres        = 2'd2;
                     res_first   = '{period: period, last: 1'b0};
                  end
               end
            end else begin
               delay_nx = delay_ff - 8'd1;
               if (sustain_ff == 4'd0) begin
                  if (!silence_ff) begin
                     silence_nx = 1'b1;
                     emit_quiet = 1'b1;
                     nres       = 2'd1;
                     res_first  = '{period: '0, last: 1'b1};
                  end
               end else begin
                  sustain_nx = sustain_ff - 4'd1;
               end
            end
         end
         default: ;
      endcase
   end

   // retire only when the queue can take every result of this item
   assign s1_go = s1_valid_ff && ((3'(nres) + 3'(fill)) <= 3'd2);
   assign push  = '{count: (s1_go ? nres : 2'd0), first: res_first, second: res_second};

   assign note_pos_in = s1_go ? note_pos_nx : note_pos_ff;
   assign delay_in    = s1_go ? delay_nx    : delay_ff;
   assign sustain_in  = s1_go ? sustain_nx  : sustain_ff;
   assign silence_in  = s1_go ? silence_nx  : silence_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_pos_ff <= 8'd0;
         delay_ff    <= 8'd0;
         sustain_ff  <= 4'd0;
         silence_ff  <= 1'b1;
      end else begin
         note_pos_ff <= note_pos_in;
         delay_ff    <= delay_in;
         sustain_ff  <= sustain_in;
         silence_ff  <= silence_in;
      end
   end

   //--------------------------------------------------------------------
   // result output
   //--------------------------------------------------------------------
   tseq_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .fill       (fill),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_delay_count: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_type_ff == REQ_TICK && delay_ff != 8'd0)
      |=> delay_ff == $past(delay_ff) - 8'd1)
      else $error("delay did not count down on a tick");

   a_quiet_once: assert property (@(posedge clock) disable iff (reset)
      (s1_go && emit_quiet) |=> silence_ff)
      else $error("silence flag not set after sending silence");

   a_pair_stop: assert property (@(posedge clock) disable iff (reset)
      (s1_go && nres == 2'd2) |-> (!loop_enable_ff && song_end))
      else $error("two results outside a song stop");
`endif

endmodule
